[hdl/ostl_pkg.sv]
`timescale 1ns / 1ps

package ostl_pkg;

  // Default sizes for the timer table.
  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned TICK_BITS_DEF = 32;

  // Fixed field widths on the stream ports.
  localparam int unsigned HANDLE_W   = 8;
  localparam int unsigned WAIT_IN_W  = 32;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned KIND_W     = 2;

  // Request codes on the input tuser.
  localparam logic REQ_ARM  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result codes on the output tuser.
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

endpackage

[hdl/ordered_software_timer_list_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                   tuser             tlast
// s_axis    in   timer_handle[7:0], wait_ticks[39:8]  req_type          -
// m_axis    out  expired_handle[7:0]                  result_kind[1:0]  last_of_run
//
// An arm word is taken only in idle; its result word is valid in the next cycle.
// A tick word scans a non-empty table in ST_SCAN, then ST_FLUSH, taking no input.
// Unless stalled, the scan reads one entry per cycle from the slot memory (one read
// and one write port) and checks it with one shared adder and comparator.
// After reset the table is empty and the tick count is zero; no clearing pass is run.
// An expired entry stalls the scan while the pending one waits on a held output word.

module ordered_software_timer_list_top #(
  parameter int unsigned CAPACITY  = ostl_pkg::CAPACITY_DEF,
  parameter int unsigned TICK_BITS = ostl_pkg::TICK_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // timer_handle[7:0], wait_ticks[39:8]
  input  logic [ostl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // expired_handle[7:0]
  output logic [ostl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // result_kind[1:0]
  output logic [ostl_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);
  import ostl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [TICK_BITS-1:0] wait_cnt;
    logic [TICK_BITS-1:0] start_tick;
  } slot_t;

  state_e               state_q;
  logic [TICK_BITS-1:0] tick_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     rd_q;
  logic [CNT_W-1:0]     wr_q;
  logic [CAPACITY-1:0]  started_q;
  logic                 pend_valid_q;
  logic [HANDLE_W-1:0]  pend_handle_q;
  logic                 out_valid_q;
  logic [KIND_W-1:0]    out_kind_q;
  logic [HANDLE_W-1:0]  out_handle_q;
  logic                 out_last_q;

  slot_t                mem [CAPACITY];
  slot_t                rd_word_q;

  logic                 s_acc;
  logic                 out_free;
  logic                 full;
  logic [HANDLE_W-1:0]  in_handle;
  logic [TICK_BITS-1:0] in_wait;
  logic [CNT_W-1:0]     rd_next;
  logic [TICK_BITS-1:0] start_eff;
  logic [TICK_BITS-1:0] due_tick;
  logic                 expire;
  logic                 advance;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  slot_t                mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;

  // Handshake and input unpacking.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_handle     = s_axis_tdata[HANDLE_W-1:0];
  assign in_wait       = TICK_BITS'(s_axis_tdata[HANDLE_W +: WAIT_IN_W]);
  assign full          = (count_q >= CNT_W'(CAPACITY));

  // Shared adder and comparator that judge the entry held in the read register.
  assign rd_next   = rd_q + CNT_W'(1);
  assign start_eff = started_q[rd_q[IDX_W-1:0]] ? rd_word_q.start_tick : tick_q;
  assign due_tick  = start_eff + rd_word_q.wait_cnt;
  assign expire    = (due_tick <= tick_q);
  assign advance   = (state_q == ST_SCAN) && !(expire && pend_valid_q && !out_free);

  // Slot memory ports: arms append at the tail, survivors compact toward the head.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = '{handle: in_handle, wait_cnt: in_wait, start_tick: '0};
    if (state_q == ST_IDLE) begin
      mem_we = s_acc && (s_axis_tuser == REQ_ARM) && !full;
    end else if (advance && !expire) begin
      mem_we    = 1'b1;
      mem_waddr = wr_q[IDX_W-1:0];
      mem_wdata = '{handle: rd_word_q.handle, wait_cnt: rd_word_q.wait_cnt,
                    start_tick: start_eff};
    end
  end

  assign mem_re    = (s_acc && (s_axis_tuser == REQ_TICK)) || advance;
  assign mem_raddr = (state_q == ST_IDLE) ? '0 : rd_next[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word_q <= mem[mem_raddr];
    end
  end

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_q        <= '0;
      count_q       <= '0;
      rd_q          <= '0;
      wr_q          <= '0;
      started_q     <= '0;
      pend_valid_q  <= 1'b0;
      pend_handle_q <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_ACCEPT;
      out_handle_q  <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser == REQ_ARM) begin
              out_valid_q  <= 1'b1;
              out_kind_q   <= full ? KIND_FULL : KIND_ACCEPT;
              out_handle_q <= in_handle;
              out_last_q   <= 1'b1;
              if (!full) begin
                started_q[count_q[IDX_W-1:0]] <= 1'b0;
                count_q                       <= count_q + CNT_W'(1);
              end
            end else begin
              tick_q <= tick_q + TICK_BITS'(1);
              rd_q   <= '0;
              wr_q   <= '0;
              if (count_q != '0) begin
                state_q <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (expire) begin
              // The previous expired handle is now known not to be the last one.
              if (pend_valid_q) begin
                out_valid_q  <= 1'b1;
                out_kind_q   <= KIND_EXPIRED;
                out_handle_q <= pend_handle_q;
                out_last_q   <= 1'b0;
              end
              pend_valid_q  <= 1'b1;
              pend_handle_q <= rd_word_q.handle;
            end else begin
              started_q[wr_q[IDX_W-1:0]] <= 1'b1;
              wr_q                       <= wr_q + CNT_W'(1);
            end
            rd_q <= rd_next;
            if (rd_next == count_q) begin
              count_q <= expire ? wr_q : wr_q + CNT_W'(1);
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= KIND_EXPIRED;
            out_handle_q <= pend_handle_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_handle_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[hdl/ostl_checker.sv]
`timescale 1ns / 1ps

module ostl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ostl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ostl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [ostl_pkg::KIND_W-1:0]    m_axis_tuser,
  input logic                           m_axis_tlast
);
  import ostl_pkg::*;

  // A result word never carries an undefined kind.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_ACCEPT || m_axis_tuser == KIND_FULL ||
                       m_axis_tuser == KIND_EXPIRED))
    else $error("result word with undefined kind");

  // Arm answers are always the only word of their run.
  a_arm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_ACCEPT || m_axis_tuser == KIND_FULL))
      |-> m_axis_tlast)
    else $error("arm answer without tlast");

  // An accepted arm word is answered in the next cycle.
  a_arm_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_ARM)
      |=> (m_axis_tvalid && (m_axis_tuser == KIND_ACCEPT || m_axis_tuser == KIND_FULL)))
    else $error("arm word not answered in the next cycle");

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
           $stable(m_axis_tlast)))
    else $error("stalled result word changed");

endmodule

bind ordered_software_timer_list_top ostl_checker u_ostl_checker (.*);
